// ===== hw/rtl/gmps_pkg.sv =====
`default_nettype none

package gmps_pkg;

   localparam int unsigned MAX_COLS_DEF   = 1024;
   localparam int unsigned MAX_ROWS_DEF   = 1024;
   localparam int unsigned COST_WIDTH_DEF = 16;

   localparam int unsigned SIZE_W      = 11;
   localparam int unsigned SUM_W       = 27;
   localparam int unsigned CSR_ADDR_W  = 1;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_ROWS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_COLS = 1'b1;

   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [SIZE_W-1:0] size_type;

   typedef struct packed {
      logic first_row;
      logic first_col;
      logic last;
   } cell_flags_type;

endpackage

`default_nettype wire

// ===== hw/rtl/gmps_queue.sv =====
`default_nettype none

module gmps_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = gmps_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/gmps_front.sv =====
`default_nettype none

module gmps_front #(
   parameter int unsigned MAX_COLS   = gmps_pkg::MAX_COLS_DEF,
   parameter int unsigned MAX_ROWS   = gmps_pkg::MAX_ROWS_DEF,
   parameter int unsigned COST_WIDTH = gmps_pkg::COST_WIDTH_DEF,
   localparam int unsigned COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [gmps_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire gmps_pkg::size_type                  csr_wdata,
   input  wire logic                                req_push,
   input  wire logic [COST_WIDTH-1:0]               req_cell_cost,
   output logic                                     req_full,
   input  wire logic                                q_full,
   output logic                                     q_push,
   output logic      [COST_WIDTH-1:0]               q_cost,
   output logic      [COL_W-1:0]                    q_col,
   output gmps_pkg::cell_flags_type                 q_flags
);

   localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int unsigned CSZ_W  = $clog2(MAX_COLS + 1);
   localparam int unsigned RSZ_W  = $clog2(MAX_ROWS + 1);

   gmps_pkg::size_type grid_rows_ff, grid_rows_in;
   gmps_pkg::size_type grid_cols_ff, grid_cols_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [CSZ_W-1:0]   cols_eff;
   logic [RSZ_W-1:0]   rows_eff;
   logic               accept;
   logic               last_col;
   logic               last_row;

   // zero reads as one, oversize saturates
   function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] m);
      logic [31:0] r;
      if (v == '0) begin
         r = 32'd1;
      end else if (v > m) begin
         r = m;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign cols_eff = CSZ_W'(clamp_size(32'(grid_cols_ff), 32'(MAX_COLS)));
   assign rows_eff = RSZ_W'(clamp_size(32'(grid_rows_ff), 32'(MAX_ROWS)));

   assign req_full = q_full || reset;
   assign accept   = req_push && !req_full;
   assign last_col = (CSZ_W'(col_ff) + CSZ_W'(1)) >= cols_eff;
   assign last_row = (RSZ_W'(row_ff) + RSZ_W'(1)) >= rows_eff;

   assign q_push            = accept;
   assign q_cost            = req_cell_cost;
   assign q_col             = col_ff;
   assign q_flags.first_row = (row_ff == '0);
   assign q_flags.first_col = (col_ff == '0);
   assign q_flags.last      = last_col && last_row;

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            gmps_pkg::CSR_GRID_ROWS: grid_rows_in = csr_wdata;
            gmps_pkg::CSR_GRID_COLS: grid_cols_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= gmps_pkg::SIZE_W'(1);
         grid_cols_ff <= gmps_pkg::SIZE_W'(1);
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/gmps_back.sv =====
`default_nettype none

module gmps_back #(
   parameter int unsigned MAX_COLS   = gmps_pkg::MAX_COLS_DEF,
   parameter int unsigned COST_WIDTH = gmps_pkg::COST_WIDTH_DEF,
   localparam int unsigned COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_empty,
   input  wire logic [COST_WIDTH-1:0]     q_cost,
   input  wire logic [COL_W-1:0]          q_col,
   input  wire gmps_pkg::cell_flags_type  q_flags,
   output logic                           q_pop,
   input  wire logic                      o_full,
   output logic                           o_push,
   output gmps_pkg::sum_type              o_sum
);

   gmps_pkg::sum_type        row_best [MAX_COLS];
   gmps_pkg::sum_type        up_ff;
   logic                     b_valid_ff, b_valid_in;
   logic [COST_WIDTH-1:0]    b_cost_ff, b_cost_in;
   logic [COL_W-1:0]         b_col_ff, b_col_in;
   gmps_pkg::cell_flags_type b_flags_ff, b_flags_in;
   gmps_pkg::sum_type        left_ff, left_in;
   logic [COL_W-1:0]         prev_col_ff, prev_col_in;
   gmps_pkg::sum_type        up;
   gmps_pkg::sum_type        low;
   gmps_pkg::sum_type        addend;
   gmps_pkg::sum_type        best;
   logic                     b_go;

   assign b_go  = b_valid_ff && (!b_flags_ff.last || !o_full);
   assign q_pop = !q_empty && (!b_valid_ff || b_go);

   // line-store read overlaps the previous cell's write: forward it
   assign up  = (prev_col_ff == b_col_ff) ? left_ff : up_ff;
   assign low = (left_ff < up) ? left_ff : up;

   always_comb begin
      case ({b_flags_ff.first_row, b_flags_ff.first_col})
         2'b11:   addend = '0;
         2'b10:   addend = left_ff;
         2'b01:   addend = up;
         default: addend = low;
      endcase
   end

   assign best   = gmps_pkg::SUM_W'(b_cost_ff) + addend;
   assign o_push = b_go && b_flags_ff.last;
   assign o_sum  = best;

   always_comb begin
      b_valid_in  = b_valid_ff;
      b_cost_in   = b_cost_ff;
      b_col_in    = b_col_ff;
      b_flags_in  = b_flags_ff;
      left_in     = left_ff;
      prev_col_in = prev_col_ff;
      if (b_go) begin
         b_valid_in  = 1'b0;
         left_in     = best;
         prev_col_in = b_col_ff;
      end
      if (q_pop) begin
         b_valid_in = 1'b1;
         b_cost_in  = q_cost;
         b_col_in   = q_col;
         b_flags_in = q_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go) begin
         row_best[b_col_ff] <= best;
      end
      if (q_pop) begin
         up_ff <= row_best[q_col];
      end
   end

   always_ff @(posedge clock) begin
      b_cost_ff  <= b_cost_in;
      b_col_ff   <= b_col_in;
      b_flags_ff <= b_flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         left_ff     <= '0;
         prev_col_ff <= '0;
      end else begin
         b_valid_ff  <= b_valid_in;
         left_ff     <= left_in;
         prev_col_ff <= prev_col_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/grid_min_path_sum_top.sv =====
// Channel   Direction  Handshake        Word
// req       in         push / full      req_cell_cost
// rsp       out        pop / empty      rsp_min_sum
// csr       in         csr_wr_en        csr_addr, csr_wdata
//
// One cell per cycle while rsp drains; line store read and written once per cycle.
// A grid result goes through the mid queue, back stage and out queue to rsp.
// Reset holds full and empty high and clears positions; line store is not cleared.
// A held rsp word stalls only the last-cell stage; two-entry queues absorb the rest.
`default_nettype none

module grid_min_path_sum_top #(
   parameter int unsigned MAX_COLS   = gmps_pkg::MAX_COLS_DEF,
   parameter int unsigned MAX_ROWS   = gmps_pkg::MAX_ROWS_DEF,
   parameter int unsigned COST_WIDTH = gmps_pkg::COST_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [gmps_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire gmps_pkg::size_type              csr_wdata,
   input  wire logic                            req_push,
   input  wire logic [COST_WIDTH-1:0]           req_cell_cost,
   output logic                                 req_full,
   input  wire logic                            rsp_pop,
   output gmps_pkg::sum_type                    rsp_min_sum,
   output logic                                 rsp_empty
);

   localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned FLAG_W = $bits(gmps_pkg::cell_flags_type);
   localparam int unsigned MID_W  = FLAG_W + COL_W + COST_WIDTH;

   logic                     f_push;
   logic [COST_WIDTH-1:0]    f_cost;
   logic [COL_W-1:0]         f_col;
   gmps_pkg::cell_flags_type f_flags;
   logic [MID_W-1:0]         mid_push_data;
   logic [MID_W-1:0]         mid_pop_data;
   logic                     mid_full;
   logic                     mid_empty;
   logic                     mid_pop;
   logic                     out_push;
   logic                     out_full;
   logic                     out_empty;
   gmps_pkg::sum_type        out_sum;

   gmps_front #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .COST_WIDTH (COST_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_cell_cost (req_cell_cost),
      .req_full      (req_full),
      .q_full        (mid_full),
      .q_push        (f_push),
      .q_cost        (f_cost),
      .q_col         (f_col),
      .q_flags       (f_flags)
   );

   assign mid_push_data = {f_flags, f_col, f_cost};

   gmps_queue #(
      .WIDTH (MID_W),
      .DEPTH (gmps_pkg::QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (mid_push_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_pop_data),
      .empty     (mid_empty)
   );

   gmps_back #(
      .MAX_COLS   (MAX_COLS),
      .COST_WIDTH (COST_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (mid_empty),
      .q_cost  (mid_pop_data[COST_WIDTH-1:0]),
      .q_col   (mid_pop_data[COST_WIDTH +: COL_W]),
      .q_flags (gmps_pkg::cell_flags_type'(mid_pop_data[MID_W-1 -: FLAG_W])),
      .q_pop   (mid_pop),
      .o_full  (out_full),
      .o_push  (out_push),
      .o_sum   (out_sum)
   );

   gmps_queue #(
      .WIDTH (gmps_pkg::SUM_W),
      .DEPTH (gmps_pkg::QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_sum),
      .full      (out_full),
      .pop       (rsp_pop && !rsp_empty),
      .pop_data  (rsp_min_sum),
      .empty     (out_empty)
   );

   assign rsp_empty = out_empty || reset;

endmodule

`default_nettype wire

// ===== hw/rtl/gmps_checker.sv =====
`default_nettype none

module gmps_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_push,
   input wire logic              req_full,
   input wire logic              rsp_pop,
   input wire logic              rsp_empty,
   input wire gmps_pkg::sum_type rsp_min_sum
);

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("rsp not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_min_sum)))
      else $error("stalled rsp word changed");

   a_empty_only_by_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> $past(rsp_pop))
      else $error("rsp word dropped without pop");

   a_full_only_by_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("req full without push");

endmodule

bind grid_min_path_sum_top gmps_checker u_gmps_checker (
   .clock       (clock),
   .reset       (reset),
   .req_push    (req_push),
   .req_full    (req_full),
   .rsp_pop     (rsp_pop),
   .rsp_empty   (rsp_empty),
   .rsp_min_sum (rsp_min_sum)
);

`default_nettype wire
